// ===== hw/rtl/sbfa_pkg.sv =====
`default_nettype none
package sbfa_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int HEADER_BYTES  = 16;
    localparam int LEN_W         = 12;
    localparam int USABLE_BYTES  = PAGE_BYTES - HEADER_BYTES;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_UNKNOWN    = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [11:0] req_size;
        logic [31:0] req_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] obj_addr;
        logic        took_page;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic wr1;
        logic wr2;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic w1_en;
        logic w2_en;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sbfa_ctrl.sv =====
`default_nettype none
module sbfa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sbfa_pkg::ctrl_cmd_t    cmd,
    input  wire sbfa_pkg::dp_stat_t stat
);
    import sbfa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WR1    = 3'd3;
    localparam logic [2:0] S_WR2    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.start  = (state_reg == S_IDLE) && in_valid;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.decide = (state_reg == S_DECIDE);
        cmd.wr1    = (state_reg == S_WR1);
        cmd.wr2    = (state_reg == S_WR2);
        cmd.load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (stat.scan_done) state_next = S_DECIDE;
            S_DECIDE: state_next = stat.w1_en ? S_WR1 : S_DONE;
            S_WR1:    state_next = stat.w2_en ? S_WR2 : S_DONE;
            S_WR2:    state_next = S_DONE;
            S_DONE:   if (cmd.load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // hold the word until taken
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sbfa_dp.sv =====
`default_nettype none
module sbfa_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sbfa_pkg::req_t      in_data,
    output sbfa_pkg::res_t           out_data,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire sbfa_pkg::ctrl_cmd_t cmd,
    output sbfa_pkg::dp_stat_t       stat
);
    import sbfa_pkg::*;

    // block table payload memory
    logic [31:0]      mem_addr [TABLE_ENTRIES];
    logic [LEN_W-1:0] mem_len  [TABLE_ENTRIES];
    logic [31:0]      mem_ord  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] vld_reg, vld_next;
    logic [TABLE_ENTRIES-1:0] fre_reg, fre_next;
    logic [31:0] oc_reg, oc_next;
    logic [15:0] pages_reg, pages_next;
    logic [31:0] heap_base_reg;
    logic [15:0] page_limit_reg;

    req_t req_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_v_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [31:0]      rd_addr_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic [31:0]      rd_ord_reg;

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_addr_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [31:0]      best_ord_reg;
    logic [1:0]       emp_reg;
    logic [IDX_W-1:0] fe_reg, se_reg;

    logic             w2_en_reg;
    logic [IDX_W-1:0] w1_idx_reg, w2_idx_reg;
    logic [31:0]      w1_addr_reg, w2_addr_reg, w1_ord_reg, w2_ord_reg;
    logic [LEN_W-1:0] w1_len_reg, w2_len_reg;
    res_t             res_reg, out_reg;

    logic take;
    always_comb
    begin
        logic ent_v, ent_f;
        ent_v = vld_reg[rd_idx_reg];
        ent_f = fre_reg[rd_idx_reg];
        if (req_reg.req_type == REQ_FREE)
            take = ent_v && !ent_f && !found_reg
                && ((rd_addr_reg + 32'(HEADER_BYTES)) == req_reg.req_addr);
        else
            take = ent_v && ent_f && (rd_len_reg >= req_reg.req_size)
                && (!found_reg || rd_len_reg < best_len_reg
                    || (rd_len_reg == best_len_reg && rd_ord_reg > best_ord_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && cnt_reg < CNT_W'(TABLE_ENTRIES))
        begin
            rd_addr_reg <= mem_addr[cnt_reg[IDX_W-1:0]];
            rd_len_reg  <= mem_len[cnt_reg[IDX_W-1:0]];
            rd_ord_reg  <= mem_ord[cnt_reg[IDX_W-1:0]];
        end
        if (cmd.wr1)
        begin
            mem_addr[w1_idx_reg] <= w1_addr_reg;
            mem_len[w1_idx_reg]  <= w1_len_reg;
            mem_ord[w1_idx_reg]  <= w1_ord_reg;
        end
        else if (cmd.wr2)
        begin
            mem_addr[w2_idx_reg] <= w2_addr_reg;
            mem_len[w2_idx_reg]  <= w2_len_reg;
            mem_ord[w2_idx_reg]  <= w2_ord_reg;
        end
    end

    // decision: flag update, write words, result
    logic [31:0]      page_addr;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] page_rem;
    logic             split, page_split;
    logic             n_w1, n_w2;
    logic [IDX_W-1:0] n_w1_idx, n_w2_idx;
    logic [31:0]      n_w1_addr, n_w2_addr, n_w1_ord, n_w2_ord;
    logic [LEN_W-1:0] n_w1_len, n_w2_len;
    res_t             n_res;

    always_comb
    begin
        page_addr  = heap_base_reg + (32'(pages_reg) << PAGE_SHIFT);
        rem        = best_len_reg - req_reg.req_size;
        page_rem   = LEN_W'(USABLE_BYTES) - req_reg.req_size;
        split      = rem > LEN_W'(HEADER_BYTES);
        page_split = page_rem > LEN_W'(HEADER_BYTES);
        vld_next   = vld_reg;
        fre_next   = fre_reg;
        oc_next    = oc_reg;
        pages_next = pages_reg;
        n_w1       = 1'b0;
        n_w2       = 1'b0;
        n_w1_idx   = best_idx_reg;
        n_w1_addr  = best_addr_reg;
        n_w1_len   = req_reg.req_size;
        n_w1_ord   = best_ord_reg;
        n_w2_idx   = fe_reg;
        n_w2_addr  = best_addr_reg + 32'(HEADER_BYTES) + 32'(req_reg.req_size);
        n_w2_len   = rem - LEN_W'(HEADER_BYTES);
        n_w2_ord   = oc_reg;
        n_res      = '0;
        if (req_reg.req_type == REQ_FREE)
        begin
            if (found_reg)
            begin
                fre_next[best_idx_reg] = 1'b1;
                n_w1     = 1'b1;
                n_w1_len = best_len_reg;
                n_w1_ord = oc_reg;
                oc_next  = oc_reg + 32'd1;
            end
            else
                n_res.status = ST_UNKNOWN;
        end
        else if (found_reg)
        begin
            if (split && emp_reg == 2'd0)
                n_res.status = ST_TABLE_FULL;
            else
            begin
                fre_next[best_idx_reg] = 1'b0;
                n_w1 = 1'b1;
                n_res.obj_addr = best_addr_reg + 32'(HEADER_BYTES);
                if (split)
                begin
                    vld_next[fe_reg] = 1'b1;
                    fre_next[fe_reg] = 1'b1;
                    n_w2    = 1'b1;
                    oc_next = oc_reg + 32'd1;
                end
            end
        end
        else if (pages_reg >= page_limit_reg
            || req_reg.req_size > LEN_W'(USABLE_BYTES))
            n_res.status = ST_EXHAUSTED;
        else if (emp_reg == 2'd0 || (page_split && emp_reg == 2'd1))
            n_res.status = ST_TABLE_FULL;
        else
        begin
            // new page: used part at first free slot, remainder at second
            vld_next[fe_reg] = 1'b1;
            fre_next[fe_reg] = 1'b0;
            n_w1       = 1'b1;
            n_w1_idx   = fe_reg;
            n_w1_addr  = page_addr;
            n_w1_ord   = oc_reg;
            oc_next    = oc_reg + 32'd1;
            pages_next = pages_reg + 16'd1;
            n_res.obj_addr  = page_addr + 32'(HEADER_BYTES);
            n_res.took_page = 1'b1;
            n_w2_idx  = se_reg;
            n_w2_addr = page_addr + 32'(HEADER_BYTES) + 32'(req_reg.req_size);
            n_w2_len  = page_rem - LEN_W'(HEADER_BYTES);
            n_w2_ord  = oc_reg + 32'd1;
            if (page_split)
            begin
                vld_next[se_reg] = 1'b1;
                fre_next[se_reg] = 1'b1;
                n_w2    = 1'b1;
                oc_next = oc_reg + 32'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            fre_reg        <= '0;
            oc_reg         <= '0;
            pages_reg      <= '0;
            heap_base_reg  <= '0;
            page_limit_reg <= 16'd256;
            cnt_reg        <= '0;
            rd_v_reg       <= 1'b0;
            found_reg      <= 1'b0;
            emp_reg        <= '0;
            w2_en_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_HEAP_BASE)
                    heap_base_reg <= cfg_data;
                else
                    page_limit_reg <= cfg_data[15:0];
            end
            if (cmd.start)
            begin
                cnt_reg   <= '0;
                rd_v_reg  <= 1'b0;
                found_reg <= 1'b0;
                emp_reg   <= '0;
            end
            if (cmd.scan)
            begin
                rd_v_reg <= cnt_reg < CNT_W'(TABLE_ENTRIES);
                if (cnt_reg < CNT_W'(TABLE_ENTRIES))
                    cnt_reg <= cnt_reg + CNT_W'(1);
                if (rd_v_reg)
                begin
                    if (take)
                        found_reg <= 1'b1;
                    if (!vld_reg[rd_idx_reg] && emp_reg != 2'd2)
                        emp_reg <= emp_reg + 2'd1;
                end
            end
            if (cmd.decide)
            begin
                vld_reg   <= vld_next;
                fre_reg   <= fre_next;
                oc_reg    <= oc_next;
                pages_reg <= pages_next;
                w2_en_reg <= n_w2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            req_reg <= in_data;
        if (cmd.scan)
        begin
            rd_idx_reg <= cnt_reg[IDX_W-1:0];
            if (rd_v_reg)
            begin
                if (take)
                begin
                    best_idx_reg  <= rd_idx_reg;
                    best_addr_reg <= rd_addr_reg;
                    best_len_reg  <= rd_len_reg;
                    best_ord_reg  <= rd_ord_reg;
                end
                if (!vld_reg[rd_idx_reg])
                begin
                    if (emp_reg == 2'd0)
                        fe_reg <= rd_idx_reg;
                    else if (emp_reg == 2'd1)
                        se_reg <= rd_idx_reg;
                end
            end
        end
        if (cmd.decide)
        begin
            w1_idx_reg  <= n_w1_idx;
            w1_addr_reg <= n_w1_addr;
            w1_len_reg  <= n_w1_len;
            w1_ord_reg  <= n_w1_ord;
            w2_idx_reg  <= n_w2_idx;
            w2_addr_reg <= n_w2_addr;
            w2_len_reg  <= n_w2_len;
            w2_ord_reg  <= n_w2_ord;
            res_reg     <= n_res;
        end
        if (cmd.load)
            out_reg <= res_reg;
    end

    assign stat.scan_done = (cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign stat.w1_en     = n_w1;
    assign stat.w2_en     = w2_en_reg;
    assign out_data       = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/segregated_best_fit_allocator_top.sv =====
`default_nettype none
// Segregated best-fit allocator. Each request word is an allocate or a free and
// returns exactly one result word. An allocate takes the smallest free block that
// fits (newest on a tie), or a fresh page from heap_base when none fits; a free
// returns a used block to the table. One request is handled at a time (accept, a
// scan of the 64-entry block table through its single read port, a decision step,
// zero to two table writes, a load of the output register). The next request is
// accepted while a result word still waits on out_stall. Configuration writes are
// always ready and are to be issued only while the block is idle.
module segregated_best_fit_allocator_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sbfa_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output sbfa_pkg::res_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import sbfa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequence the scan, decision and table writes
    sbfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // hold the table, registers and result word
    sbfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
